FILE: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_core.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic                          ins;
    logic                          rem;
    logic signed [VALUE_WIDTH-1:0] value;
  } spq_cmd_t;

endpackage

FILE: design/spq_cell.sv
// One slot of the sorted queue: holds a value and shifts with its neighbors.
// Depends on spq_pkg for the command struct and value width.
module spq_cell
  import spq_pkg::*;
(
  input  logic                          clk,
  input  spq_cmd_t                      cmd,
  input  logic                          occ,
  input  logic                          left_keep,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  output logic                          keep,
  output logic signed [VALUE_WIDTH-1:0] value
);

  logic signed [VALUE_WIDTH-1:0] value_next;

  assign keep = occ && (value >= cmd.value);

  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (!keep) begin
        value_next = left_keep ? cmd.value : left_value;
      end
    end else if (cmd.rem) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: design/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a row of spq_cell slots plus count.
// Depends on spq_pkg and spq_cell.
// Latency: the result strobes on done in the cycle right after start is taken.
// Start is not taken while busy, so no new item is taken before the last is through;
// the cells insert or shift as start is taken, and busy stays high through the result cycle.
// Reset: clears the entry count and the done strobe; slot contents are kept.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic signed [31:0]            value,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [31:0]            head_value,
  output logic                          is_empty,
  output logic [4:0]                    entry_count
);

  logic [COUNT_W-1:0]            count;
  logic [COUNT_W-1:0]            count_next;
  status_t                       stat;
  status_t                       stat_next;
  spq_cmd_t                      cmd;
  logic                          accept;
  logic                          full;
  logic                          empty;
  logic [QUEUE_DEPTH-1:0]        keep;
  logic [QUEUE_DEPTH-1:0]        occ;
  logic signed [VALUE_WIDTH-1:0] slot [QUEUE_DEPTH];

  assign accept = start && !busy;
  assign full   = (count == COUNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign busy   = done;

  always_comb begin
    cmd        = '0;
    cmd.value  = value;
    count_next = count;
    stat_next  = ST_DONE;
    unique case (func_t'(func))
      FUNC_INSERT: begin
        if (full) begin
          stat_next = ST_FULL;
        end else begin
          cmd.ins    = accept;
          count_next = count + COUNT_W'(1);
        end
      end
      FUNC_REMOVE: begin
        if (empty) begin
          stat_next = ST_EMPTY;
        end else begin
          cmd.rem    = accept;
          count_next = count - COUNT_W'(1);
        end
      end
      FUNC_CLEAR: count_next = '0;
      default:    count_next = count;
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occ[i] = (COUNT_W'(i) < count);
      if (i == 0) begin : g_first
        spq_cell u_cell (
          .clk         (clk),
          .cmd         (cmd),
          .occ         (occ[i]),
          .left_keep   (1'b1),
          .left_value  (slot[i]),
          .right_value (slot[i+1]),
          .keep        (keep[i]),
          .value       (slot[i])
        );
      end else if (i == QUEUE_DEPTH - 1) begin : g_last
        spq_cell u_cell (
          .clk         (clk),
          .cmd         (cmd),
          .occ         (occ[i]),
          .left_keep   (keep[i-1]),
          .left_value  (slot[i-1]),
          .right_value (slot[i]),
          .keep        (keep[i]),
          .value       (slot[i])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk         (clk),
          .cmd         (cmd),
          .occ         (occ[i]),
          .left_keep   (keep[i-1]),
          .left_value  (slot[i-1]),
          .right_value (slot[i+1]),
          .keep        (keep[i]),
          .value       (slot[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat <= stat_next;
    end
  end

  assign status      = stat;
  assign head_value  = empty ? 32'sd0 : slot[0];
  assign is_empty    = empty;
  assign entry_count = 5'(count);

`ifndef NO_ASSERTIONS
  a_one_cycle_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted item gave no result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && stat == ST_FULL) |-> full)
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && stat == ST_EMPTY) |-> empty)
    else $error("empty status with entries stored");
`endif

endmodule
